### design/arrt_pkg.sv
`timescale 1ns / 1ps
package arrt_pkg;

    localparam int HANDLE_W = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_LOOKUP     = 2'd2
    } arrt_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_REJECT = 2'd1,
        STS_MISS   = 2'd2,
        STS_FULL   = 2'd3
    } arrt_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_COMMIT
    } arrt_state_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic eval;        // capture the match flag
        logic mode_lookup; // span containment instead of handle compare
        logic wr_update;   // selected cell takes new base and limit
        logic wr_append;   // tail cell takes the whole key
        logic wr_remove;   // cells at or after the match take their neighbor
    } arrt_cell_ctrl_t;

endpackage

### design/arrt_req_if.sv
`timescale 1ns / 1ps
interface arrt_req_if #(
    parameter int ADDR_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [15:0]           buffer_handle;
    logic [ADDR_WIDTH-1:0] region_base;
    logic [ADDR_WIDTH-1:0] region_size;
    logic                  is_device;
    logic [ADDR_WIDTH-1:0] probe_addr;
    logic [ADDR_WIDTH-1:0] probe_len;

    modport source (
        output valid, cmd, buffer_handle, region_base, region_size, is_device,
               probe_addr, probe_len,
        input  ready
    );

    modport sink (
        input  valid, cmd, buffer_handle, region_base, region_size, is_device,
               probe_addr, probe_len,
        output ready
    );
endinterface

### design/arrt_rsp_if.sv
`timescale 1ns / 1ps
interface arrt_rsp_if #(
    parameter int ADDR_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [15:0]           found_handle;
    logic [ADDR_WIDTH-1:0] found_offset;

    modport source (
        output valid, status, found_handle, found_offset,
        input  ready
    );

    modport sink (
        input  valid, status, found_handle, found_offset,
        output ready
    );
endinterface

### design/arrt_cell.sv
`timescale 1ns / 1ps
module arrt_cell #(
    parameter int ADDR_WIDTH = 48
) (
    input  logic                            clk,
    input  arrt_pkg::arrt_cell_ctrl_t       ctrl,
    input  logic                            in_use,
    input  logic                            is_tail,
    input  logic [arrt_pkg::HANDLE_W-1:0]   key_handle,
    input  logic [ADDR_WIDTH-1:0]           key_base,
    input  logic [ADDR_WIDTH:0]             key_limit,
    input  logic [ADDR_WIDTH-1:0]           probe_addr,
    input  logic [ADDR_WIDTH:0]             probe_end,
    input  logic                            prior_in,
    output logic                            prior_out,
    output logic                            sel,
    input  logic [arrt_pkg::HANDLE_W-1:0]   nb_handle,
    input  logic [ADDR_WIDTH-1:0]           nb_base,
    input  logic [ADDR_WIDTH:0]             nb_limit,
    output logic [arrt_pkg::HANDLE_W-1:0]   handle,
    output logic [ADDR_WIDTH-1:0]           base,
    output logic [ADDR_WIDTH:0]             limit
);
    import arrt_pkg::*;

    logic [HANDLE_W-1:0]   handle_reg;
    logic [ADDR_WIDTH-1:0] base_reg;
    logic [ADDR_WIDTH:0]   limit_reg;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  contains;

    // limit holds base + length, so the span fits when it ends at or below it
    assign contains = (probe_addr >= base_reg) && (probe_end <= limit_reg);

    always_comb
    begin
        if (ctrl.mode_lookup)
        begin
            hit_next = in_use && contains;
        end
        else
        begin
            hit_next = in_use && (handle_reg == key_handle);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.eval)
        begin
            hit_reg <= hit_next;
        end
    end

    // first hit in table order wins
    assign sel       = hit_reg && !prior_in;
    assign prior_out = prior_in || hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_remove && prior_out)
        begin
            handle_reg <= nb_handle;
            base_reg   <= nb_base;
            limit_reg  <= nb_limit;
        end
        else if (ctrl.wr_update && sel)
        begin
            base_reg  <= key_base;
            limit_reg <= key_limit;
        end
        else if (ctrl.wr_append && is_tail)
        begin
            handle_reg <= key_handle;
            base_reg   <= key_base;
            limit_reg  <= key_limit;
        end
    end

    assign handle = handle_reg;
    assign base   = base_reg;
    assign limit  = limit_reg;

endmodule

### design/address_range_region_table_core.sv
`timescale 1ns / 1ps
// Ordered table of address regions with register, unregister and span lookup.
//
// Channels: req carries one command beat (cmd, handle, base, size, device
// flag, probe address and length); rsp returns exactly one beat per command
// with status, found handle and offset into the region.
//
// Each table entry lives in a cell of a chain. A command has an evaluate state,
// which compares the key against every cell at once and registers a flag per
// cell, and a commit state, which resolves the first flag in table order
// along the chain, applies the update and loads the response register. Removal
// shifts every later cell down by one from its neighbor in that same cycle.
//
// The next request is taken in the commit cycle of the previous command.
//
// Reset empties the table (entry count to zero) and drops any pending
// response. While the receiver holds rsp.ready low with a response waiting,
// a command in its commit cycle holds and no further request is taken.
module address_range_region_table_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int ADDR_WIDTH  = 48
) (
    input  logic       clk,
    input  logic       rst_n,
    arrt_req_if.sink   req,
    arrt_rsp_if.source rsp
);
    import arrt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    arrt_state_t           state_reg;
    arrt_state_t           state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;

    arrt_cmd_t             cmd_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [ADDR_WIDTH-1:0] base_reg;
    logic [ADDR_WIDTH:0]   limit_reg;
    logic                  dev_reg;
    logic [ADDR_WIDTH-1:0] paddr_reg;
    logic [ADDR_WIDTH:0]   pend_reg;

    logic                  out_valid_reg;
    arrt_status_t          status_reg;
    logic [HANDLE_W-1:0]   fh_reg;
    logic [ADDR_WIDTH-1:0] fo_reg;

    logic                  req_fire;
    logic                  commit_go;
    logic                  table_full;
    arrt_cell_ctrl_t       ctrl;
    arrt_status_t          status_next;
    logic [HANDLE_W-1:0]   fh_next;
    logic [ADDR_WIDTH-1:0] fo_next;

    logic [TABLE_DEPTH:0]   prior;
    logic [TABLE_DEPTH-1:0] sel;
    logic                   any_hit;
    logic [HANDLE_W-1:0]    cell_handle [TABLE_DEPTH];
    logic [ADDR_WIDTH-1:0]  cell_base   [TABLE_DEPTH];
    logic [ADDR_WIDTH:0]    cell_limit  [TABLE_DEPTH];
    logic [HANDLE_W-1:0]    sel_handle;
    logic [ADDR_WIDTH-1:0]  sel_base;

    assign commit_go  = (state_reg == S_COMMIT) && (!out_valid_reg || rsp.ready);
    assign req.ready  = (state_reg == S_IDLE) || commit_go;
    assign req_fire   = req.valid && req.ready;
    assign table_full = (cnt_reg == CNT_W'(TABLE_DEPTH));

    // capture the request beat; both sums are formed once here for all cells
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg    <= arrt_cmd_t'(req.cmd);
            handle_reg <= req.buffer_handle;
            base_reg   <= req.region_base;
            limit_reg  <= {1'b0, req.region_base} + {1'b0, req.region_size};
            dev_reg    <= req.is_device;
            paddr_reg  <= req.probe_addr;
            pend_reg   <= {1'b0, req.probe_addr} + {1'b0, req.probe_len};
        end
    end

    assign prior[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic [HANDLE_W-1:0]   nb_handle;
            logic [ADDR_WIDTH-1:0] nb_base;
            logic [ADDR_WIDTH:0]   nb_limit;

            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign nb_handle = '0;
                assign nb_base   = '0;
                assign nb_limit  = '0;
            end
            else
            begin : g_mid
                assign nb_handle = cell_handle[gi+1];
                assign nb_base   = cell_base[gi+1];
                assign nb_limit  = cell_limit[gi+1];
            end

            arrt_cell #(
                .ADDR_WIDTH (ADDR_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .in_use     (cnt_reg > CNT_W'(gi)),
                .is_tail    (cnt_reg == CNT_W'(gi)),
                .key_handle (handle_reg),
                .key_base   (base_reg),
                .key_limit  (limit_reg),
                .probe_addr (paddr_reg),
                .probe_end  (pend_reg),
                .prior_in   (prior[gi]),
                .prior_out  (prior[gi+1]),
                .sel        (sel[gi]),
                .nb_handle  (nb_handle),
                .nb_base    (nb_base),
                .nb_limit   (nb_limit),
                .handle     (cell_handle[gi]),
                .base       (cell_base[gi]),
                .limit      (cell_limit[gi])
            );
        end
    endgenerate

    assign any_hit = prior[TABLE_DEPTH];

    always_comb
    begin
        sel_handle = '0;
        sel_base   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sel_handle = sel_handle | ({HANDLE_W{sel[i]}} & cell_handle[i]);
            sel_base   = sel_base | ({ADDR_WIDTH{sel[i]}} & cell_base[i]);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = req_fire ? S_EVAL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs: cell control, response and entry count
    always_comb
    begin
        ctrl             = '0;
        ctrl.eval        = (state_reg == S_EVAL);
        ctrl.mode_lookup = (cmd_reg == CMD_LOOKUP);
        status_next      = STS_REJECT;
        fh_next          = '0;
        fo_next          = '0;
        cnt_next         = cnt_reg;
        case (cmd_reg)
            CMD_REGISTER:
            begin
                if (handle_reg == '0 || !dev_reg || base_reg == '0)
                begin
                    status_next = STS_REJECT;
                end
                else if (any_hit)
                begin
                    status_next    = STS_OK;
                    ctrl.wr_update = commit_go;
                end
                else if (table_full)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    status_next    = STS_OK;
                    ctrl.wr_append = commit_go;
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
            end
            CMD_UNREGISTER:
            begin
                if (handle_reg == '0)
                begin
                    status_next = STS_REJECT;
                end
                else if (!any_hit)
                begin
                    status_next = STS_MISS;
                end
                else
                begin
                    status_next    = STS_OK;
                    ctrl.wr_remove = commit_go;
                    cnt_next       = cnt_reg - CNT_W'(1);
                end
            end
            CMD_LOOKUP:
            begin
                if (paddr_reg == '0 || !any_hit)
                begin
                    status_next = STS_MISS;
                end
                else
                begin
                    status_next = STS_OK;
                    fh_next     = sel_handle;
                    fo_next     = paddr_reg - sel_base;
                end
            end
            default:
            begin
                status_next = STS_REJECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit_go)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_go)
        begin
            status_reg <= status_next;
            fh_reg     <= fh_next;
            fo_reg     <= fo_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.found_handle = fh_reg;
    assign rsp.found_offset = fo_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_one_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> $onehot0(sel))
        else $error("more than one cell selected");

    a_append_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_append |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("append did not grow the table");

    a_remove_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_remove |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("removal did not shrink the table");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fh_reg != '0) |-> (status_reg == STS_OK))
        else $error("handle reported without success");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import arrt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_WIDTH  = 48;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 400;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam logic [ADDR_WIDTH-1:0] ADDR_MAX = {ADDR_WIDTH{1'b1}};

    // idling phases
    localparam int PH_STEADY    = 0;
    localparam int PH_SRC_IDLE  = 1;
    localparam int PH_SNK_STALL = 2;
    localparam int PH_BOTH      = 3;

    typedef struct {
        logic [1:0]            cmd;
        logic [15:0]           buffer_handle;
        logic [ADDR_WIDTH-1:0] region_base;
        logic [ADDR_WIDTH-1:0] region_size;
        logic                  is_device;
        logic [ADDR_WIDTH-1:0] probe_addr;
        logic [ADDR_WIDTH-1:0] probe_len;
        int                    phase;
        bit                    drain_first;
    } region_cmd_t;

    typedef struct {
        arrt_status_t          status;
        logic [15:0]           found_handle;
        logic [ADDR_WIDTH-1:0] found_offset;
    } region_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    arrt_req_if #(.ADDR_WIDTH(ADDR_WIDTH)) req_ch ();
    arrt_rsp_if #(.ADDR_WIDTH(ADDR_WIDTH)) rsp_ch ();

    address_range_region_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow of the region table
    logic [15:0]           shadow_handle [TABLE_DEPTH];
    logic [ADDR_WIDTH-1:0] shadow_base   [TABLE_DEPTH];
    logic [ADDR_WIDTH-1:0] shadow_length [TABLE_DEPTH];
    int                    shadow_count = 0;

    region_cmd_t pending_cmd_q[$];
    region_rsp_t expected_rsp_q[$];
    region_cmd_t cur_cmd;
    int          cur_phase = PH_STEADY;
    int          cmds_accepted = 0;
    int          rsps_checked = 0;
    int          total_cmds = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    int          gen_phase = PH_STEADY;
    bit          gen_drain = 1'b0;
    logic [ADDR_WIDTH-1:0] recent_base[$];
    logic [ADDR_WIDTH-1:0] recent_size[$];

    function automatic int locate_handle(logic [15:0] h);
        int idx;
        idx = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--)
        begin
            if (shadow_handle[i] == h)
                idx = i;
        end
        return idx;
    endfunction

    function automatic region_rsp_t apply_region_cmd(region_cmd_t c);
        region_rsp_t           r;
        int                    idx;
        logic [ADDR_WIDTH-1:0] off;
        bit                    hit;
        r.status       = STS_OK;
        r.found_handle = '0;
        r.found_offset = '0;
        hit            = 1'b0;
        case (c.cmd)
            CMD_REGISTER:
            begin
                if (c.buffer_handle == '0 || !c.is_device || c.region_base == '0)
                    r.status = STS_REJECT;
                else
                begin
                    idx = locate_handle(c.buffer_handle);
                    if (idx < shadow_count)
                    begin
                        shadow_base[idx]   = c.region_base;
                        shadow_length[idx] = c.region_size;
                    end
                    else if (shadow_count >= TABLE_DEPTH)
                        r.status = STS_FULL;
                    else
                    begin
                        shadow_handle[shadow_count] = c.buffer_handle;
                        shadow_base[shadow_count]   = c.region_base;
                        shadow_length[shadow_count] = c.region_size;
                        shadow_count++;
                    end
                end
            end
            CMD_UNREGISTER:
            begin
                if (c.buffer_handle == '0)
                    r.status = STS_REJECT;
                else
                begin
                    idx = locate_handle(c.buffer_handle);
                    if (idx >= shadow_count)
                        r.status = STS_MISS;
                    else
                    begin
                        // close the gap, keep order
                        for (int i = idx; i + 1 < shadow_count; i++)
                        begin
                            shadow_handle[i] = shadow_handle[i + 1];
                            shadow_base[i]   = shadow_base[i + 1];
                            shadow_length[i] = shadow_length[i + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            CMD_LOOKUP:
            begin
                if (c.probe_addr != '0)
                begin
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        if (!hit && c.probe_addr >= shadow_base[i])
                        begin
                            off = c.probe_addr - shadow_base[i];
                            if (off <= shadow_length[i] && c.probe_len <= shadow_length[i] - off)
                            begin
                                hit            = 1'b1;
                                r.found_handle = shadow_handle[i];
                                r.found_offset = off;
                            end
                        end
                    end
                end
                if (!hit)
                    r.status = STS_MISS;
            end
            default:
                r.status = STS_REJECT;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_WIDTH-1:0] rand_addr();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[ADDR_WIDTH-1:0];
    endfunction

    task automatic add_cmd(logic [1:0] cmd, logic [15:0] h, logic [ADDR_WIDTH-1:0] base,
                           logic [ADDR_WIDTH-1:0] size, logic dev,
                           logic [ADDR_WIDTH-1:0] probe, logic [ADDR_WIDTH-1:0] plen);
        region_cmd_t c;
        c.cmd           = cmd;
        c.buffer_handle = h;
        c.region_base   = base;
        c.region_size   = size;
        c.is_device     = dev;
        c.probe_addr    = probe;
        c.probe_len     = plen;
        c.phase         = gen_phase;
        c.drain_first   = gen_drain;
        gen_drain       = 1'b0;
        if (cmd == CMD_REGISTER && base != '0)
        begin
            recent_base.insert(recent_base.size(), base);
            recent_size.insert(recent_size.size(), size);
            if (recent_base.size() > 16)
            begin
                void'(recent_base.pop_front());
                void'(recent_size.pop_front());
            end
        end
        pending_cmd_q.insert(pending_cmd_q.size(), c);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_req
        bit          fire;
        bit          next_valid;
        region_cmd_t nxt;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            fire = req_ch.valid && req_ch.ready;
            if (fire)
            begin
                expected_rsp_q.insert(expected_rsp_q.size(), apply_region_cmd(cur_cmd));
                cmds_accepted++;
            end
            if (!req_ch.valid || fire)
            begin
                next_valid = 1'b0;
                if (pending_cmd_q.size() > 0)
                begin
                    nxt = pending_cmd_q[0];
                    if (nxt.drain_first && cmds_accepted != rsps_checked)
                        next_valid = 1'b0;
                    else if ($urandom_range(99) < ((nxt.phase == PH_SRC_IDLE) ? 51 :
                                                   (nxt.phase == PH_BOTH) ? 16 : 0))
                        next_valid = 1'b0;
                    else
                    begin
                        void'(pending_cmd_q.pop_front());
                        cur_cmd                <= nxt;
                        cur_phase              <= nxt.phase;
                        req_ch.cmd             <= nxt.cmd;
                        req_ch.buffer_handle   <= nxt.buffer_handle;
                        req_ch.region_base     <= nxt.region_base;
                        req_ch.region_size     <= nxt.region_size;
                        req_ch.is_device       <= nxt.is_device;
                        req_ch.probe_addr      <= nxt.probe_addr;
                        req_ch.probe_len       <= nxt.probe_len;
                        next_valid             = 1'b1;
                    end
                end
                req_ch.valid <= next_valid;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : watch_rsp
        region_rsp_t exp_rsp;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("response beat with no command outstanding");
                    error_count++;
                end
                else
                begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (rsp_ch.status !== exp_rsp.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_rsp.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.found_handle !== exp_rsp.found_handle)
                    begin
                        $error("found_handle mismatch: expected %h, actual %h",
                               exp_rsp.found_handle, rsp_ch.found_handle);
                        error_count++;
                    end
                    if (rsp_ch.found_offset !== exp_rsp.found_offset)
                    begin
                        $error("found_offset mismatch: expected %h, actual %h",
                               exp_rsp.found_offset, rsp_ch.found_offset);
                        error_count++;
                    end
                end
                rsps_checked <= rsps_checked + 1;
            end
            rsp_ch.ready <= ($urandom_range(99) >= ((cur_phase == PH_SNK_STALL) ? 51 :
                                                    (cur_phase == PH_BOTH) ? 16 : 0));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                    kind;
        int                    k;
        logic [15:0]           h;
        logic [ADDR_WIDTH-1:0] base;
        logic [ADDR_WIDTH-1:0] size;
        logic [ADDR_WIDTH-1:0] probe;
        logic [ADDR_WIDTH-1:0] plen;
        logic [ADDR_WIDTH-1:0] rem;
        logic [63:0]           off64;
        logic                  dev;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_REGISTER;
        req_ch.buffer_handle = '0;
        req_ch.region_base   = '0;
        req_ch.region_size   = '0;
        req_ch.is_device     = 1'b0;
        req_ch.probe_addr    = '0;
        req_ch.probe_len     = '0;
        rsp_ch.ready         = 1'b0;

        // directed: empty table, refusals, extremes, full table, removal order
        add_cmd(CMD_LOOKUP, 16'h0, '0, '0, 1'b0, 48'h1, 48'h0);
        add_cmd(CMD_LOOKUP, 16'h3, 48'h1000, 48'h10, 1'b1, 48'h0, 48'h0);
        add_cmd(CMD_REGISTER, 16'h0, 48'h1000, 48'h100, 1'b1, '0, '0);
        add_cmd(CMD_REGISTER, 16'h7, 48'h1000, 48'h100, 1'b0, '0, '0);
        add_cmd(CMD_REGISTER, 16'h7, 48'h0, 48'h100, 1'b1, '0, '0);
        add_cmd(CMD_RESERVED, 16'hFFFF, ADDR_MAX, ADDR_MAX, 1'b1, ADDR_MAX, ADDR_MAX);
        add_cmd(CMD_UNREGISTER, 16'h0, '0, '0, 1'b1, '0, '0);
        add_cmd(CMD_UNREGISTER, 16'h5, '0, '0, 1'b1, '0, '0);
        add_cmd(CMD_REGISTER, 16'hFFFF, ADDR_MAX, 48'h0, 1'b1, '0, '0);
        add_cmd(CMD_REGISTER, 16'h1, 48'h1000, 48'h100, 1'b1, '0, '0);
        add_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, 48'h1000, 48'h100);
        // zero-length span at the very end of a region
        add_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, 48'h1100, 48'h0);
        add_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, 48'h1100, 48'h1);
        add_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, ADDR_MAX, 48'h0);
        add_cmd(CMD_REGISTER, 16'h1, 48'h1, ADDR_MAX, 1'b1, '0, '0);
        for (int i = 2; i < TABLE_DEPTH; i++)
            add_cmd(CMD_REGISTER, 16'(i), 48'h1000, 48'h100, 1'b1, '0, '0);
        add_cmd(CMD_REGISTER, 16'h10, 48'h2000, 48'h10, 1'b1, '0, '0);
        // existing handle still updates with the table full
        add_cmd(CMD_REGISTER, 16'h2, 48'h8000, 48'h10, 1'b1, '0, '0);
        add_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, 48'h1010, 48'h10);
        add_cmd(CMD_UNREGISTER, 16'h1, '0, '0, 1'b0, '0, '0);
        add_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, 48'h1010, 48'h10);
        add_cmd(CMD_UNREGISTER, 16'hFFFF, '0, '0, 1'b0, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gen_phase = n / (RANDOM_ITEMS / 4);
            if (n % (RANDOM_ITEMS / 4) == 0)
                gen_drain = 1'b1;
            kind  = $urandom_range(99);
            h     = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(20, 1));
            base  = rand_addr();
            size  = rand_addr();
            probe = rand_addr();
            plen  = rand_addr();
            dev   = 1'($urandom);
            if (kind < 35)
            begin
                case ($urandom_range(9))
                    0: base = rand_addr();
                    1: base = '0;
                    2: base = ADDR_MAX;
                    default: base = ADDR_WIDTH'($urandom_range(64, 1)) << 12;
                endcase
                case ($urandom_range(9))
                    0: size = rand_addr();
                    1: size = '0;
                    2: size = ADDR_MAX;
                    default: size = ADDR_WIDTH'($urandom_range(16'h3000));
                endcase
                dev = ($urandom_range(11) != 0);
                add_cmd(CMD_REGISTER, h, base, size, dev, probe, plen);
            end
            else if (kind < 57)
                add_cmd(CMD_UNREGISTER, h, base, size, dev, probe, plen);
            else if (kind < 95)
            begin
                k = $urandom_range(19);
                if (k == 0)
                    probe = '0;
                else if (k > 3 && recent_base.size() > 0)
                begin
                    // span aimed at a region registered earlier
                    k     = $urandom_range(recent_base.size() - 1);
                    off64 = {$urandom, $urandom} % ({16'h0, recent_size[k]} + 64'd1);
                    rem   = recent_size[k] - off64[ADDR_WIDTH-1:0];
                    if ($urandom_range(9) == 0)
                        plen = rem + 1'b1;
                    else
                        plen = ADDR_WIDTH'({$urandom, $urandom} % ({16'h0, rem} + 64'd1));
                    probe = recent_base[k] + off64[ADDR_WIDTH-1:0];
                end
                add_cmd(CMD_LOOKUP, h, base, size, dev, probe, plen);
            end
            else
                add_cmd(CMD_RESERVED, h, base, size, dev, probe, plen);
        end
        total_cmds = pending_cmd_q.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (cmds_accepted != total_cmds)
            @(posedge clk);
        while (rsps_checked != cmds_accepted)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_rsp_q.size() != 0)
        begin
            $error("%0d expected responses never arrived", expected_rsp_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
